// File: sv/lbb_pkg.sv
// Shared types, constants and envelope tables for the LED blink/breathe controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package lbb_pkg;

  localparam int unsigned NOW_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned TICKS_W    = 8;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned IDX_W      = 6;
  // Pulse period times ticks per millisecond fits in 24 bits.
  localparam int unsigned PTICKS_W   = PERIOD_W + TICKS_W;

  // Reciprocals of the table lengths, scaled by 2^RECIP_SHIFT and rounded down.
  // For a 24-bit dividend the scaled product falls short of the quotient by at most one.
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_GREEN = 25'd23342213;
  localparam logic [RECIP_W-1:0] RECIP_RED   = 25'd23860929;

  localparam logic [IDX_W-1:0]    STEPS_GREEN  = 6'd46;
  localparam logic [IDX_W-1:0]    STEPS_RED    = 6'd45;
  localparam logic [DUTY_W-1:0]   DUTY_FULL    = 8'd255;
  localparam logic [PERIOD_W-1:0] BLINK_RESET  = 16'd250;
  localparam logic [PERIOD_W-1:0] PULSE_RESET  = 16'd1500;
  localparam logic [TICKS_W-1:0]  TICKS_RESET  = 8'd48;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_PULSE = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_COLOUR       = 3'd1,
    REG_BLINK_PERIOD = 3'd2,
    REG_PULSE_PERIOD = 3'd3,
    REG_TICKS        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic capture;     // latch the timestamp of an accepted request
    logic advance;     // advance the carrier, update blink, form period ticks
    logic div_load;    // estimate the step length, start the pulse if needed
    logic div_step;    // correct the estimate and form the remainder
    logic pulse_step;  // take one envelope step
    logic emit;        // load the result register
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  step_ready;  // enough carrier ticks have gone by for the next step
  } status_t;

  localparam logic [DUTY_W-1:0] ENV_GREEN [46] = '{
    8'd0,   8'd1,   8'd2,   8'd4,   8'd7,   8'd11,  8'd16,  8'd22,
    8'd29,  8'd37,  8'd46,  8'd56,  8'd67,  8'd79,  8'd92,  8'd106,
    8'd121, 8'd137, 8'd154, 8'd172, 8'd191, 8'd211, 8'd232, 8'd255,
    8'd232, 8'd211, 8'd191, 8'd172, 8'd154, 8'd137, 8'd121, 8'd106,
    8'd92,  8'd79,  8'd67,  8'd56,  8'd46,  8'd37,  8'd29,  8'd22,
    8'd16,  8'd11,  8'd7,   8'd4,   8'd2,   8'd1
  };

  localparam logic [DUTY_W-1:0] ENV_RED [45] = '{
    8'd0,   8'd4,   8'd7,   8'd11,  8'd16,  8'd23,  8'd31,  8'd40,
    8'd50,  8'd61,  8'd73,  8'd86,  8'd100, 8'd115, 8'd131, 8'd148,
    8'd166, 8'd185, 8'd205, 8'd225, 8'd245, 8'd252, 8'd255, 8'd255,
    8'd252, 8'd245, 8'd225, 8'd205, 8'd185, 8'd166, 8'd148, 8'd131,
    8'd115, 8'd100, 8'd86,  8'd73,  8'd61,  8'd50,  8'd40,  8'd31,
    8'd23,  8'd16,  8'd11,  8'd7,   8'd4
  };

  function automatic logic [DUTY_W-1:0] env_duty(logic red, logic [IDX_W-1:0] idx);
    logic [DUTY_W-1:0] d;
    d = '0;
    if (red) begin
      if (idx < STEPS_RED) d = ENV_RED[idx];
    end else begin
      if (idx < STEPS_GREEN) d = ENV_GREEN[idx];
    end
    return d;
  endfunction

endpackage

// File: sv/lbb_in_if.sv
// Timestamp request channel of the LED blink/breathe controller.
// Depends on lbb_pkg for the field width.
interface lbb_in_if import lbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface

// File: sv/lbb_out_if.sv
// Result channel of the LED blink/breathe controller.
// Depends on lbb_pkg for the field width.
interface lbb_out_if import lbb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              led_on;
  logic              led_red;
  logic [DUTY_W-1:0] duty;

  modport source (output valid, output led_on, output led_red, output duty, input ready);
  modport sink (input valid, input led_on, input led_red, input duty, output ready);
endinterface

// File: sv/lbb_cfg_if.sv
// Register write channel of the LED blink/breathe controller.
// Depends on lbb_pkg for the index and data widths.
interface lbb_cfg_if import lbb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/lbb_ctrl.sv
// Sequencing state machine of the LED blink/breathe controller.
// Depends on lbb_pkg for the command and status structs.
module lbb_ctrl import lbb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_DIV_LOAD,
    ST_DIV,
    ST_STEP,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit;

  assign emit = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.emit  = emit;
    out_valid_d = emit || (out_valid_q && !out_ready_i);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd_o.advance = 1'b1;
        state_d = (status_i.mode == MODE_PULSE) ? ST_DIV_LOAD : ST_DONE;
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_STEP;
      end
      ST_STEP: begin
        // One envelope step a cycle until the carrier has not yet reached the next one.
        cmd_o.pulse_step = status_i.step_ready;
        if (!status_i.step_ready) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (emit) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/lbb_datapath.sv
// Datapath of the LED blink/breathe controller: registers, carrier counter,
// blink timer, step-length divider and breathing envelope walk. Depends on lbb_pkg.
module lbb_datapath import lbb_pkg::*; #(
  parameter int unsigned CATCHUP_LIMIT_MS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [NOW_W-1:0]      now_ms_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  led_on_o,
  output logic                  led_red_o,
  output logic [DUTY_W-1:0]     duty_o
);

  localparam int unsigned CAP_W        = $clog2(CATCHUP_LIMIT_MS + 1);
  localparam int unsigned PROD_W       = CAP_W + TICKS_W;
  localparam int unsigned RECIP_PROD_W = PTICKS_W + RECIP_W;

  // Configuration registers.
  mode_e               mode_q;
  logic                colour_q;
  logic [PERIOD_W-1:0] blink_period_q;
  logic [PERIOD_W-1:0] pulse_period_q;
  logic [TICKS_W-1:0]  ticks_q;

  // Envelope state.
  logic [NOW_W-1:0] last_time_q, carrier_q;
  logic             blink_started_q, blink_lit_q;
  logic [NOW_W-1:0] blink_start_q;
  logic             pulse_started_q;
  logic [NOW_W-1:0] epoch_q;
  logic [IDX_W-1:0] index_q, error_q;

  // Working registers, no reset needed.
  logic [NOW_W-1:0]    now_q;
  logic [PTICKS_W-1:0] pticks_q;
  logic [PTICKS_W-1:0] quo_q;
  logic [IDX_W-1:0]    rem_q;
  logic                on_q, red_q;
  logic [DUTY_W-1:0]   duty_q;

  logic                    restart;
  logic [NOW_W-1:0]        elapsed, blink_ref, pulse_elapsed;
  logic [CAP_W-1:0]        capped;
  logic [PROD_W-1:0]       adv_ticks;
  logic [IDX_W-1:0]        steps;
  logic [RECIP_W-1:0]      recip;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [PTICKS_W-1:0]     quo_est, rem_est;
  logic                    rem_over;
  logic [IDX_W:0]          err_sum;
  logic                    carry;
  logic [IDX_W-1:0]        err_next, index_next;
  logic [PTICKS_W-1:0]     len_raw, len;
  logic                    blink_toggle;
  logic                    on_d, red_d;
  logic [DUTY_W-1:0]       duty_d;

  assign restart = cfg_we_i && (cfg_index_i == REG_MODE || cfg_index_i == REG_COLOUR ||
                   cfg_index_i == REG_BLINK_PERIOD || cfg_index_i == REG_PULSE_PERIOD ||
                   cfg_index_i == REG_TICKS);

  // Carrier advance, with catch-up capped.
  assign elapsed   = now_q - last_time_q;
  assign capped    = (elapsed > NOW_W'(CATCHUP_LIMIT_MS)) ? CAP_W'(CATCHUP_LIMIT_MS)
                                                          : elapsed[CAP_W-1:0];
  assign adv_ticks = PROD_W'(capped) * PROD_W'(ticks_q);

  // Blink: the first blink request fixes the reference time.
  assign blink_ref    = blink_started_q ? blink_start_q : now_q;
  assign blink_toggle = (now_q - blink_ref) >= NOW_W'(blink_period_q);

  // Period ticks over the table length: the reciprocal product gives a quotient that
  // is at most one short, and a single compare and subtract puts it right.
  assign steps      = colour_q ? STEPS_RED : STEPS_GREEN;
  assign recip      = colour_q ? RECIP_RED : RECIP_GREEN;
  assign recip_prod = RECIP_PROD_W'(pticks_q) * RECIP_PROD_W'(recip);
  assign quo_est    = PTICKS_W'(recip_prod[RECIP_PROD_W-1:RECIP_SHIFT]);
  assign rem_est    = pticks_q - quo_q * PTICKS_W'(steps);
  assign rem_over   = rem_est >= PTICKS_W'(steps);

  // Length of the next step: base length plus one where the error overflows, at least one.
  assign err_sum  = {1'b0, error_q} + {1'b0, rem_q};
  assign carry    = err_sum >= {1'b0, steps};
  assign err_next = carry ? IDX_W'(err_sum - {1'b0, steps}) : err_sum[IDX_W-1:0];
  assign len_raw  = quo_q + PTICKS_W'(carry);
  assign len      = (len_raw == '0) ? PTICKS_W'(1) : len_raw;
  assign pulse_elapsed = carrier_q - epoch_q;
  assign index_next = (index_q == steps - 1'b1) ? '0 : index_q + 1'b1;

  assign status_o.mode       = mode_q;
  assign status_o.step_ready = pulse_elapsed >= NOW_W'(len);

  always_comb begin
    on_d   = 1'b0;
    red_d  = 1'b0;
    duty_d = '0;
    case (mode_q)
      MODE_ON: begin
        on_d   = 1'b1;
        red_d  = colour_q;
        duty_d = DUTY_FULL;
      end
      MODE_BLINK: begin
        on_d   = blink_lit_q;
        red_d  = blink_lit_q && colour_q;
        duty_d = blink_lit_q ? DUTY_FULL : '0;
      end
      MODE_PULSE: begin
        on_d   = 1'b1;
        red_d  = colour_q;
        duty_d = env_duty(colour_q, index_q);
      end
      default: begin
        on_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_OFF;
      colour_q        <= 1'b0;
      blink_period_q  <= BLINK_RESET;
      pulse_period_q  <= PULSE_RESET;
      ticks_q         <= TICKS_RESET;
      last_time_q     <= '0;
      carrier_q       <= '0;
      blink_started_q <= 1'b0;
      blink_start_q   <= '0;
      blink_lit_q     <= 1'b0;
      pulse_started_q <= 1'b0;
      epoch_q         <= '0;
      index_q         <= '0;
      error_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MODE:         mode_q         <= mode_e'(cfg_data_i[1:0]);
          REG_COLOUR:       colour_q       <= cfg_data_i[0];
          REG_BLINK_PERIOD: blink_period_q <= cfg_data_i;
          REG_PULSE_PERIOD: pulse_period_q <= cfg_data_i;
          REG_TICKS:        ticks_q        <= cfg_data_i[TICKS_W-1:0];
          default: begin
          end
        endcase
      end
      if (restart) begin
        blink_started_q <= 1'b0;
        blink_start_q   <= '0;
        blink_lit_q     <= 1'b0;
        pulse_started_q <= 1'b0;
        epoch_q         <= '0;
        index_q         <= '0;
        error_q         <= '0;
      end else begin
        if (cmd_i.advance) begin
          if (elapsed != '0) begin
            last_time_q <= now_q;
            carrier_q   <= carrier_q + NOW_W'(adv_ticks);
          end
          if (mode_q == MODE_BLINK) begin
            blink_started_q <= 1'b1;
            if (blink_toggle) begin
              blink_lit_q   <= !blink_lit_q;
              blink_start_q <= now_q;
            end else begin
              blink_start_q <= blink_ref;
            end
          end
        end
        if (cmd_i.div_load && !pulse_started_q) begin
          pulse_started_q <= 1'b1;
          epoch_q         <= carrier_q;
          index_q         <= '0;
          error_q         <= '0;
        end
        if (cmd_i.pulse_step) begin
          error_q <= err_next;
          epoch_q <= epoch_q + NOW_W'(len);
          index_q <= index_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) now_q <= now_ms_i;
    if (cmd_i.advance) pticks_q <= PTICKS_W'(pulse_period_q) * PTICKS_W'(ticks_q);
    if (cmd_i.div_load) begin
      quo_q <= quo_est;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_q + PTICKS_W'(rem_over);
      rem_q <= rem_over ? IDX_W'(rem_est - PTICKS_W'(steps)) : IDX_W'(rem_est);
    end
    if (cmd_i.emit) begin
      on_q   <= on_d;
      red_q  <= red_d;
      duty_q <= duty_d;
    end
  end

  assign led_on_o  = on_q;
  assign led_red_o = red_q;
  assign duty_o    = duty_q;

endmodule

// File: sv/led_blink_breathe_controller.sv
// LED blink/breathe controller. Each request on in_i carries a millisecond timestamp
// and yields exactly one result on out_o: LED on, red/green channel and PWM duty.
// Registers are written over cfg_i (index 0 mode, 1 colour, 2 blink period,
// 3 pulse period, 4 ticks per millisecond); cfg_i is always ready and a write to one
// of these restarts the current mode. Registers are to be written only while the
// block is idle. The block works on one request at a time. Off, steady on and blink
// pass an advance state, then a done state that loads the result register. Breathing
// pulse adds a divide-load and a divide state between them, which divide the period
// ticks by the table length (a reciprocal multiply, then one correcting subtraction),
// and a step state taking N envelope steps, one a cycle; N is at most the carrier ticks
// advanced by this request plus one. A finished result waits in the output register
// while a new request is accepted; a stalled receiver holds the result and the next
// one waits in its last cycle. Reset restores the register defaults, clears the
// carrier count and all mode state, and leaves the output channel empty.
// Depends on lbb_pkg, lbb_in_if, lbb_out_if, lbb_cfg_if, lbb_ctrl and lbb_datapath.
module led_blink_breathe_controller import lbb_pkg::*; #(
  parameter int unsigned CATCHUP_LIMIT_MS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbb_in_if.sink    in_i,
  lbb_out_if.source out_o,
  lbb_cfg_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  lbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lbb_datapath #(
    .CATCHUP_LIMIT_MS (CATCHUP_LIMIT_MS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .now_ms_i    (in_i.now_ms),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .led_on_o    (out_o.led_on),
    .led_red_o   (out_o.led_red),
    .duty_o      (out_o.duty)
  );

`ifndef SYNTHESIS
  // A request is worked on alone: no second acceptance directly after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while the previous one is in progress");

  // Loading the result register always presents a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_o.valid)
    else $error("result loaded but not presented");

  // A dark LED drives no channel and no duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.led_on) |-> (out_o.duty == '0 && !out_o.led_red))
    else $error("dark result carries colour or duty");

  // The walk only runs in breathing pulse mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pulse_step |-> (status.mode == MODE_PULSE))
    else $error("envelope step outside pulse mode");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_blink_breathe_controller: drives timestamp requests,
// predicts every LED result from its own copy of the envelope state and checks each one.
// Depends on lbb_pkg and the lbb_in_if, lbb_out_if and lbb_cfg_if interfaces.
module testbench;
  import lbb_pkg::*;

  localparam int unsigned CATCHUP_MS  = 10;
  localparam int unsigned GREEN_STEPS = 46;
  localparam int unsigned RED_STEPS   = 45;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned REPORT_MAX  = 10;

  localparam logic [DUTY_W-1:0] GREEN_CURVE [GREEN_STEPS] = '{
    8'd0,   8'd1,   8'd2,   8'd4,   8'd7,   8'd11,  8'd16,  8'd22,
    8'd29,  8'd37,  8'd46,  8'd56,  8'd67,  8'd79,  8'd92,  8'd106,
    8'd121, 8'd137, 8'd154, 8'd172, 8'd191, 8'd211, 8'd232, 8'd255,
    8'd232, 8'd211, 8'd191, 8'd172, 8'd154, 8'd137, 8'd121, 8'd106,
    8'd92,  8'd79,  8'd67,  8'd56,  8'd46,  8'd37,  8'd29,  8'd22,
    8'd16,  8'd11,  8'd7,   8'd4,   8'd2,   8'd1
  };

  localparam logic [DUTY_W-1:0] RED_CURVE [RED_STEPS] = '{
    8'd0,   8'd4,   8'd7,   8'd11,  8'd16,  8'd23,  8'd31,  8'd40,
    8'd50,  8'd61,  8'd73,  8'd86,  8'd100, 8'd115, 8'd131, 8'd148,
    8'd166, 8'd185, 8'd205, 8'd225, 8'd245, 8'd252, 8'd255, 8'd255,
    8'd252, 8'd245, 8'd225, 8'd205, 8'd185, 8'd166, 8'd148, 8'd131,
    8'd115, 8'd100, 8'd86,  8'd73,  8'd61,  8'd50,  8'd40,  8'd31,
    8'd23,  8'd16,  8'd11,  8'd7,   8'd4
  };

  typedef struct packed {
    logic              lit;
    logic              red;
    logic [DUTY_W-1:0] duty;
  } led_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lbb_in_if  in_if ();
  lbb_out_if out_if ();
  lbb_cfg_if cfg_if ();

  led_blink_breathe_controller u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copy and envelope state of the predictor.
  mode_e               cfg_mode  = MODE_OFF;
  logic                cfg_red   = 1'b0;
  logic [PERIOD_W-1:0] cfg_blink = 16'd250;
  logic [PERIOD_W-1:0] cfg_pulse = 16'd1500;
  logic [TICKS_W-1:0]  cfg_ticks = 8'd48;
  logic [NOW_W-1:0]    last_stamp = '0;
  logic [31:0]         carrier = '0;
  logic                blink_run = 1'b0;
  logic [NOW_W-1:0]    blink_mark = '0;
  logic                blink_on = 1'b0;
  logic                pulse_run = 1'b0;
  logic [31:0]         pulse_mark = '0;
  int unsigned         pulse_pos = 0;
  int unsigned         pulse_err = 0;

  led_result_t led_expected [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_request = 0;
  logic [NOW_W-1:0] timeline = '0;

  function automatic void restart_envelope();
    blink_run  = 1'b0;
    blink_mark = '0;
    blink_on   = 1'b0;
    pulse_run  = 1'b0;
    pulse_mark = '0;
    pulse_pos  = 0;
    pulse_err  = 0;
  endfunction

  function automatic void apply_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:         cfg_mode  = mode_e'(data[1:0]);
      REG_COLOUR:       cfg_red   = data[0];
      REG_BLINK_PERIOD: cfg_blink = data;
      REG_PULSE_PERIOD: cfg_pulse = data;
      REG_TICKS:        cfg_ticks = data[TICKS_W-1:0];
      default:          return;
    endcase
    restart_envelope();
  endfunction

  function automatic led_result_t predict_led(logic [NOW_W-1:0] stamp);
    led_result_t res;
    logic [31:0] gap;
    logic [31:0] gone;
    int unsigned steps, pticks, base, rem, acc, len;
    res = '0;
    gap = stamp - last_stamp;
    if (gap != 0) begin
      last_stamp = stamp;
      if (gap > CATCHUP_MS) gap = CATCHUP_MS;
      carrier = carrier + gap * cfg_ticks;
    end
    case (cfg_mode)
      MODE_ON: begin
        res.lit  = 1'b1;
        res.duty = 8'd255;
      end
      MODE_BLINK: begin
        if (!blink_run) begin
          blink_run  = 1'b1;
          blink_mark = stamp;
        end
        if (32'(stamp - blink_mark) >= cfg_blink) begin
          blink_on   = !blink_on;
          blink_mark = stamp;
        end
        res.lit  = blink_on;
        res.duty = blink_on ? 8'd255 : 8'd0;
      end
      MODE_PULSE: begin
        steps  = cfg_red ? RED_STEPS : GREEN_STEPS;
        pticks = cfg_pulse * cfg_ticks;
        base   = pticks / steps;
        rem    = pticks % steps;
        if (!pulse_run) begin
          pulse_run  = 1'b1;
          pulse_mark = carrier;
          pulse_pos  = 0;
          pulse_err  = 0;
        end
        // The remainder is spread over the steps, so some steps are one tick longer.
        forever begin
          gone = carrier - pulse_mark;
          acc  = pulse_err + rem;
          len  = base;
          if (acc >= steps) begin
            acc -= steps;
            len++;
          end
          if (len == 0) len = 1;
          if (gone < len) break;
          pulse_err  = acc;
          pulse_mark = pulse_mark + len;
          pulse_pos++;
          if (pulse_pos >= steps) pulse_pos = 0;
        end
        res.lit  = 1'b1;
        res.duty = cfg_red ? RED_CURVE[pulse_pos] : GREEN_CURVE[pulse_pos];
      end
      default: res = '0;
    endcase
    res.red = res.lit ? cfg_red : 1'b0;
    return res;
  endfunction

  // Offers one timestamp request; returns at the falling edge after acceptance with
  // valid still high, so that back-to-back requests keep it asserted.
  task automatic send_stamp(logic [NOW_W-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.now_ms <= stamp;
    do @(posedge clk_i); while (!in_if.ready);
    led_expected.push_back(predict_led(stamp));
    @(negedge clk_i);
  endtask

  // Registers are only written once every outstanding result has been taken.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    in_if.valid <= 1'b0;
    while (led_expected.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_off_and_timestamps();
    send_stamp(32'h0000_0000);
    send_stamp(32'h0000_0000);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(32'h0000_0005);
  endtask

  task automatic test_steady_on();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_ON));
    send_stamp(32'h0000_0006);
  endtask

  task automatic test_blink_zero_period();
    write_reg(REG_BLINK_PERIOD, 16'd0);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_BLINK));
    send_stamp(32'd10);
    send_stamp(32'd10);
    send_stamp(32'd11);
  endtask

  task automatic test_pulse_without_ticks();
    write_reg(REG_TICKS, 16'd0);
    write_reg(REG_COLOUR, 16'd1);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_PULSE));
    send_stamp(32'd20);
    send_stamp(32'd40);
  endtask

  task automatic test_pulse_short_step();
    // Forty-five ticks over the green table's 46 steps gives a step length of zero.
    write_reg(REG_TICKS, 16'd1);
    write_reg(REG_PULSE_PERIOD, 16'd45);
    write_reg(REG_COLOUR, 16'd0);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_PULSE));
    send_stamp(32'd41);
    send_stamp(32'd42);
    send_stamp(32'd43);
    send_stamp(32'd60);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_TICKS, 16'd255);
    write_reg(REG_PULSE_PERIOD, 16'd65535);
    write_reg(REG_COLOUR, 16'd1);
    write_reg(REG_BLINK_PERIOD, 16'd65535);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_BLINK));
    send_stamp(32'd61);
    send_stamp(32'd70);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_PULSE));
    send_stamp(32'd80);
    send_stamp(32'd200);
  endtask

  task automatic test_long_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_MODE, CFG_DATA_W'(MODE_ON));
    hold_request = 1;
    for (int i = 0; i < 30; i++) send_stamp(32'd300 + i);
  endtask

  task automatic pick_random_setting();
    int unsigned sel;
    if ($urandom_range(1)) write_reg(REG_COLOUR, CFG_DATA_W'($urandom_range(1)));
    if ($urandom_range(1)) begin
      sel = $urandom_range(9);
      write_reg(REG_BLINK_PERIOD, sel == 0 ? 16'd1 : sel == 1 ? 16'd65535 :
                sel == 2 ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 30)));
    end
    if ($urandom_range(1)) begin
      sel = $urandom_range(9);
      write_reg(REG_PULSE_PERIOD, sel == 0 ? 16'd45 : sel == 1 ? 16'd65535 :
                sel == 2 ? 16'($urandom_range(45, 65535)) : 16'($urandom_range(45, 300)));
    end
    if ($urandom_range(1)) begin
      sel = $urandom_range(5);
      write_reg(REG_TICKS, sel == 0 ? 16'd1 : sel == 1 ? 16'd255 :
                16'($urandom_range(1, 255)));
    end
    write_reg(REG_MODE, CFG_DATA_W'($urandom_range(3)));
  endtask

  // Mostly a steady millisecond clock, with repeats, catch-up gaps, steps back and
  // the odd arbitrary timestamp.
  task automatic test_random_phase(int unsigned tx_pct, int unsigned rx_pct, int n);
    int unsigned sel;
    int run_left;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        pick_random_setting();
        run_left = $urandom_range(20, 60);
      end
      sel = $urandom_range(99);
      if (sel < 70)      timeline = timeline + $urandom_range(1, 3);
      else if (sel < 88) timeline = timeline + (sel < 80 ? 0 : $urandom_range(4, 40));
      else if (sel < 94) timeline = timeline - $urandom_range(1, 50);
      else               timeline = $urandom();
      send_stamp(timeline);
      run_left--;
    end
  endtask

  task automatic finish_run();
    in_if.valid <= 1'b0;
    while (led_expected.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    mismatch_count += led_expected.size();
    if (mismatch_count == 0) begin
      $display("led_blink_breathe_controller verification clean");
    end else begin
      $display("led_blink_breathe_controller verification failed");
    end
    $finish;
  endtask

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = LONG_HOLD;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    led_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (led_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: on=%0d red=%0d duty=%0d",
                   out_if.led_on, out_if.led_red, out_if.duty);
      end else begin
        want = led_expected.pop_front();
        if (out_if.led_on !== want.lit || out_if.led_red !== want.red ||
            out_if.duty !== want.duty) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result mismatch: expected on=%0d red=%0d duty=%0d, got on=%0d red=%0d duty=%0d",
                     want.lit, want.red, want.duty,
                     out_if.led_on, out_if.led_red, out_if.duty);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no request moved for %0d cycles", STALL_LIMIT);
        $display("led_blink_breathe_controller verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid  <= 1'b0;
    in_if.now_ms <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_MODE;
    cfg_if.data  <= '0;
    send_idle_pct = 11;
    recv_idle_pct = 79;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_off_and_timestamps();
    test_steady_on();
    test_blink_zero_period();
    test_pulse_without_ticks();
    test_pulse_short_step();
    test_register_extremes();
    test_long_stall();
    test_random_phase(11, 79, 300);
    test_random_phase(79, 11, 300);
    test_random_phase(0, 0, 300);
    finish_run();
  end

endmodule
